FILE: design/rln_pkg.sv
// Shared constants for the row L2 normalizer.
package rln_pkg;

    localparam int MAX_ROW_DEF   = 64;
    localparam int ELEM_BITS_DEF = 16;

    localparam int ELEM_W_MAX  = 16;
    localparam int LEN_W       = 7;
    localparam int SUM_W       = 37;
    localparam int MAG_W       = ELEM_W_MAX + 1;
    localparam int Q_BITS      = 15;
    localparam int OUT_W       = Q_BITS + 1;
    localparam int FRAC_SHIFT  = 2 * Q_BITS;
    localparam int ACC_W       = 68;
    localparam int K_W         = $clog2(Q_BITS);

endpackage

FILE: design/rln_norm_unit.sv
// Bit-serial search for the largest q with q*q*sum <= mag*mag*2^30.
module rln_norm_unit
    import rln_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MAG_W-1:0]   mag,
    input  logic [SUM_W-1:0]   sum,
    output logic               done,
    output logic [Q_BITS-1:0]  q
);

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [K_W-1:0]      k_reg;
    logic [K_W-1:0]      k_next;
    logic [ACC_W-1:0]    t_reg;
    logic [ACC_W-1:0]    t_next;
    logic [ACC_W-1:0]    p_reg;
    logic [ACC_W-1:0]    p_next;
    logic [ACC_W-1:0]    r_reg;
    logic [ACC_W-1:0]    r_next;
    logic [ACC_W-1:0]    sk_reg;
    logic [ACC_W-1:0]    sk_next;
    logic [Q_BITS-1:0]   q_reg;
    logic [Q_BITS-1:0]   q_next;
    logic [2*MAG_W-1:0]  mag_sq;
    logic [ACC_W-1:0]    cand;
    logic                fit;

    assign mag_sq = mag * mag;
    assign cand   = p_reg + r_reg + sk_reg;
    assign fit    = (cand <= t_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        t_next    = t_reg;
        p_next    = p_reg;
        r_next    = r_reg;
        sk_next   = sk_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = K_W'(Q_BITS - 1);
            t_next    = ACC_W'(mag_sq) << FRAC_SHIFT;
            p_next    = '0;
            r_next    = '0;
            sk_next   = ACC_W'(sum) << (2 * (Q_BITS - 1));
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            sk_next = sk_reg >> 2;
            if (fit)
            begin
                p_next = cand;
                r_next = (r_reg >> 1) + sk_reg;
                q_next = q_reg | (Q_BITS'(1) << k_reg);
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg - K_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg  <= k_next;
        t_reg  <= t_next;
        p_reg  <= p_next;
        r_reg  <= r_next;
        sk_reg <= sk_next;
        q_reg  <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

FILE: design/row_l2_normalizer.sv
// Row L2 normalizer: stores a row, sums squares, emits each element over the row norm in Q1.15.
//
//  channel | signals                          | word
//  --------+----------------------------------+--------------------------------
//  in      | in_valid, in_ready               | element_value
//  out     | out_valid, out_ready             | norm_value, row_end
//  cfg     | cfg_valid, cfg_ready             | row_length
//
//  An element is accepted whenever in_valid and in_ready are both high; the row lands in a one-port RAM.
//  Each result passes through one RAM read, one setup state, 15 steps of the bit-serial norm unit,
//  its registered done flag and the load of the output register.
//  Reset clears the fill count, the square sum and the control; the RAM is not cleared.
//  in_ready stays low while a row is being emitted; a stalled output holds the unit.
module row_l2_normalizer
    import rln_pkg::*;
#(
    parameter int MAX_ROW   = MAX_ROW_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [LEN_W-1:0]        row_length,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [ELEM_W_MAX-1:0] element_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] norm_value,
    output logic                    row_end
);

    localparam int ELEM_W = (ELEM_BITS < ELEM_W_MAX) ? ELEM_BITS : ELEM_W_MAX;
    localparam int CNT_W  = $clog2(MAX_ROW + 1);
    localparam int ADDR_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

    typedef enum logic [2:0] {
        S_FILL,
        S_READ,
        S_START,
        S_ITER,
        S_EMIT
    } state_t;

    state_t                    state_reg;
    logic [LEN_W-1:0]          row_length_reg;
    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic signed [ELEM_W-1:0]  rd_data_reg;
    logic signed [OUT_W-1:0]   norm_reg;
    logic                      row_end_reg;
    logic                      out_valid_reg;

    logic signed [ELEM_W-1:0]  row_mem [MAX_ROW];

    logic [LEN_W-1:0]          len_eff;
    logic [CNT_W-1:0]          fill_idx;
    logic [CNT_W-1:0]          fill_inc;
    logic signed [ELEM_W-1:0]  x_in;
    logic signed [MAG_W-1:0]   x_in_ext;
    logic [MAG_W-1:0]          a_in;
    logic [2*MAG_W-1:0]        a_sq;
    logic                      in_fire;
    logic                      row_done;
    logic signed [MAG_W-1:0]   x_rd_ext;
    logic [MAG_W-1:0]          a_rd;
    logic                      unit_start;
    logic                      unit_done;
    logic [Q_BITS-1:0]         unit_q;
    logic signed [OUT_W-1:0]   q_signed;
    logic                      emit_fire;
    logic                      last_item;

    always_comb
    begin
        if (row_length_reg == '0)
            len_eff = LEN_W'(1);
        else if (row_length_reg > LEN_W'(MAX_ROW))
            len_eff = LEN_W'(MAX_ROW);
        else
            len_eff = row_length_reg;
    end

    assign fill_idx = (fill_reg >= CNT_W'(MAX_ROW)) ? CNT_W'(MAX_ROW - 1) : fill_reg;
    assign fill_inc = fill_idx + CNT_W'(1);
    assign row_done = (LEN_W'(fill_inc) >= len_eff);

    assign x_in     = element_value[ELEM_W-1:0];
    assign x_in_ext = MAG_W'(x_in);
    assign a_in     = x_in_ext[MAG_W-1] ? MAG_W'(-x_in_ext) : MAG_W'(x_in_ext);
    assign a_sq     = a_in * a_in;

    assign x_rd_ext = MAG_W'(rd_data_reg);
    assign a_rd     = x_rd_ext[MAG_W-1] ? MAG_W'(-x_rd_ext) : MAG_W'(x_rd_ext);

    assign in_ready   = (state_reg == S_FILL);
    assign in_fire    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign unit_start = (state_reg == S_START);
    assign emit_fire  = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign last_item  = ((idx_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        if (sum_reg == '0)
            q_signed = '0;
        else if (rd_data_reg[ELEM_W-1])
            q_signed = -$signed({1'b0, unit_q});
        else
            q_signed = $signed({1'b0, unit_q});
    end

    rln_norm_unit u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .mag   (a_rd),
        .sum   (sum_reg),
        .done  (unit_done),
        .q     (unit_q)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
            row_mem[fill_idx[ADDR_W-1:0]] <= x_in;
        if (state_reg == S_READ)
            rd_data_reg <= row_mem[idx_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            row_length_reg <= LEN_W'(MAX_ROW_DEF);
            fill_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
            norm_reg       <= '0;
            row_end_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                row_length_reg <= row_length;
            if (out_valid_reg && out_ready && !emit_fire)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_FILL:
                begin
                    if (in_fire)
                    begin
                        sum_reg <= sum_reg + SUM_W'(a_sq);
                        if (row_done)
                        begin
                            fill_reg  <= '0;
                            count_reg <= fill_inc;
                            idx_reg   <= '0;
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            fill_reg <= fill_inc;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (unit_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        norm_reg      <= q_signed;
                        row_end_reg   <= last_item;
                        out_valid_reg <= 1'b1;
                        if (last_item)
                        begin
                            sum_reg   <= '0;
                            state_reg <= S_FILL;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CNT_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_FILL;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign norm_value = norm_reg;
    assign row_end    = row_end_reg;

endmodule

FILE: tb/row_l2_normalizer_test.sv
// Self-checking testbench for the row L2 normalizer: random and directed rows against a predictor.
module row_l2_normalizer_test;
    import rln_pkg::*;

    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 100;
    localparam int Q_LIMIT        = 32767;

    typedef enum int
    {
        SHAPE_FULL,
        SHAPE_SMALL,
        SHAPE_ZERO,
        SHAPE_SPIKE,
        SHAPE_EXTREME
    } row_shape_t;

    typedef struct packed
    {
        logic signed [OUT_W-1:0] norm;
        logic                    row_last;
    } norm_word_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [LEN_W-1:0]             row_length;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [ELEM_W_MAX-1:0] element_value;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [OUT_W-1:0]      norm_value;
    logic                         row_end;

    norm_word_t                   expected_words[$];
    logic signed [ELEM_W_MAX-1:0] row_copy[MAX_ROW_DEF];
    int                           stored_count;
    logic [SUM_W-1:0]             square_total;
    logic [LEN_W-1:0]             active_length;

    int  mismatch_count;
    int  words_checked;
    int  elements_sent;
    int  rows_done;
    int  idle_cycles;
    bit  tx_burst;
    bit  rx_burst;
    bit  long_hold;

    row_l2_normalizer u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .row_length    (row_length),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .norm_value    (norm_value),
        .row_end       (row_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic signed [OUT_W-1:0] scaled_element(
        input logic signed [ELEM_W_MAX-1:0] x,
        input logic [SUM_W-1:0]             s
    );
        logic [16:0]             mag;
        logic [16:0]             q;
        logic [16:0]             cand;
        logic [79:0]             target;
        logic [79:0]             probe;
        logic signed [OUT_W-1:0] r;
        if (s == 0)
            return '0;
        mag = (x < 0) ? 17'(-int'(x)) : 17'(x);
        target = (80'(mag) * 80'(mag)) << FRAC_SHIFT;
        q = '0;
        for (int k = 16; k >= 0; k--)
        begin
            cand = q | (17'(1) << k);
            probe = 80'(cand) * 80'(cand) * 80'(s);
            if (probe <= target)
                q = cand;
        end
        if (q > Q_LIMIT)
            q = Q_LIMIT;
        r = q[OUT_W-1:0];
        return (x < 0) ? -r : r;
    endfunction

    function automatic void absorb_element(input logic signed [ELEM_W_MAX-1:0] x);
        int               len;
        logic [SUM_W-1:0] mag;
        norm_word_t       w;
        if (active_length == 0)
            len = 1;
        else if (active_length > MAX_ROW_DEF)
            len = MAX_ROW_DEF;
        else
            len = active_length;
        if (stored_count >= MAX_ROW_DEF)
            stored_count = MAX_ROW_DEF - 1;
        row_copy[stored_count] = x;
        mag = (x < 0) ? SUM_W'(-int'(x)) : SUM_W'(x);
        square_total = square_total + mag * mag;
        stored_count++;
        if (stored_count >= len)
        begin
            for (int i = 0; i < stored_count; i++)
            begin
                w.norm = scaled_element(row_copy[i], square_total);
                w.row_last = (i == stored_count - 1);
                expected_words.push_back(w);
            end
            rows_done++;
            stored_count = 0;
            square_total = '0;
        end
    endfunction

    function automatic logic signed [ELEM_W_MAX-1:0] random_element(input row_shape_t shape);
        logic signed [ELEM_W_MAX-1:0] x;
        case (shape)
            SHAPE_SMALL:
                x = ELEM_W_MAX'(int'($urandom_range(0, 16)) - 8);
            SHAPE_ZERO:
                x = '0;
            SHAPE_EXTREME:
                case ($urandom_range(0, 4))
                    0: x = 16'sh7FFF;
                    1: x = 16'sh8000;
                    2: x = 16'sh8001;
                    3: x = 16'sh0001;
                    default: x = 16'shFFFF;
                endcase
            default:
                x = ELEM_W_MAX'($urandom_range(0, 65535));
        endcase
        return x;
    endfunction

    task automatic send_element(input logic signed [ELEM_W_MAX-1:0] x);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        element_value <= x;
        do @(posedge clk); while (!in_ready);
        absorb_element(x);
        elements_sent++;
    endtask

    task automatic send_row(input row_shape_t shape, input int count);
        int spot;
        spot = $urandom_range(0, count - 1);
        for (int i = 0; i < count; i++)
        begin
            if (shape == SHAPE_SPIKE)
                send_element((i == spot) ? random_element(SHAPE_FULL) : '0);
            else
                send_element(random_element(shape));
        end
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        @(negedge clk);
        cfg_valid <= 1'b1;
        row_length <= len;
        do @(posedge clk); while (!cfg_ready);
        active_length = len;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_length();
        send_row(SHAPE_FULL, MAX_ROW_DEF);
        wait_for_drain();
    endtask

    task automatic test_lone_elements();
        write_length(7'd1);
        send_element(16'sh7FFF);
        send_element(16'sh8000);
        send_element(16'sh0000);
        send_element(16'sh0001);
        send_element(16'shFFFF);
        wait_for_drain();
    endtask

    task automatic test_length_zero();
        write_length(7'd0);
        send_element(-16'sd5);
        send_element(16'sh0000);
        wait_for_drain();
    endtask

    task automatic test_extreme_rows();
        write_length(7'd4);
        send_element(16'sh7FFF);
        send_element(16'sh8000);
        send_element(16'sh8000);
        send_element(16'sh7FFF);
        repeat (4) send_element(16'sh0000);
        send_element(16'sh0000);
        send_element(16'sh0000);
        send_element(16'sh8000);
        send_element(16'sh0000);
        wait_for_drain();
    endtask

    task automatic test_mid_row_change();
        write_length(7'd8);
        for (int i = 0; i < 5; i++)
            send_element(ELEM_W_MAX'(i * 1000 - 2000));
        wait_for_drain();
        write_length(7'd3);
        send_element(16'sh0007);
        wait_for_drain();
    endtask

    task automatic test_length_saturation();
        write_length(7'h7F);
        send_row(SHAPE_FULL, MAX_ROW_DEF);
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        write_length(7'd16);
        long_hold = 1'b1;
        tx_burst = 1'b1;
        send_row(SHAPE_FULL, 48);
        tx_burst = 1'b0;
        wait_for_drain();
        send_row(SHAPE_FULL, 16);
        wait_for_drain();
    endtask

    task automatic test_random_rows();
        int         first;
        int         len;
        int         eff;
        int         rows;
        int         pick;
        row_shape_t shape;
        first = elements_sent;
        while (elements_sent - first < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0: len = 0;
                1: len = $urandom_range(65, 127);
                2: len = $urandom_range(13, 64);
                default: len = $urandom_range(1, 12);
            endcase
            write_length(LEN_W'(len));
            eff = (len == 0) ? 1 : ((len > MAX_ROW_DEF) ? MAX_ROW_DEF : len);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            rows = $urandom_range(1, (eff >= 24) ? 1 : 24 / eff);
            for (int r = 0; r < rows; r++)
            begin
                pick = $urandom_range(0, 7);
                shape = (pick > 4) ? SHAPE_FULL : row_shape_t'(pick);
                if (eff > 1 && $urandom_range(0, 9) == 0)
                begin
                    send_row(shape, $urandom_range(1, eff - 1));
                    break;
                end
                send_row(shape, eff);
            end
            wait_for_drain();
            tx_burst = 1'b0;
            rx_burst = 1'b0;
        end
    endtask

    // drain the output side; a pending long hold becomes the next stall
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold)
            begin
                stall = LONG_HOLD;
                long_hold = 1'b0;
            end
            else
                stall = rx_burst ? 0 : $urandom_range(0, 8);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        norm_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected word: norm %0d row_end %0b", norm_value, row_end);
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (norm_value !== want.norm || row_end !== want.row_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("word %0d: expected norm %0d row_end %0b, got norm %0d row_end %0b",
                                 words_checked, $signed(want.norm), want.row_last,
                                 norm_value, row_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[row_l2_normalizer] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        row_length = '0;
        in_valid = 1'b0;
        element_value = '0;
        stored_count = 0;
        square_total = '0;
        active_length = LEN_W'(MAX_ROW_DEF);
        mismatch_count = 0;
        words_checked = 0;
        elements_sent = 0;
        rows_done = 0;
        idle_cycles = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        long_hold = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_length();
        test_lone_elements();
        test_length_zero();
        test_extreme_rows();
        test_mid_row_change();
        test_length_saturation();
        test_backpressure();
        test_random_rows();
        wait_for_drain();

        $display("run: %0d elements in, %0d words checked over %0d rows, %0d mismatches",
                 elements_sent, words_checked, rows_done, mismatch_count);
        $display("run: lengths 0 to 127, mid-row length change, zero and saturating rows, long output stall");
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("[row_l2_normalizer] OK");
        else
            $display("[row_l2_normalizer] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
design/rln_pkg.sv
design/rln_norm_unit.sv
design/row_l2_normalizer.sv
tb/row_l2_normalizer_test.sv
